// ===== rtl/core/tsps_pkg.sv =====
`timescale 1ns / 1ps
// tsps_pkg: shared constants and modular helper for the totient sieve
// no dependencies

package tsps_pkg;

    localparam int LIMIT_W = 17;
    localparam int NUM_W   = 17;
    localparam int TOT_W   = 16;
    localparam int SUM_W   = 30;
    localparam int TAG_W   = 4;

    localparam logic [SUM_W-1:0] MODULUS = 30'd998244353;

    // sum of two residues, reduced once
    function automatic logic [SUM_W-1:0] add_mod(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, MODULUS})
            s = s - {1'b0, MODULUS};
        return s[SUM_W-1:0];
    endfunction

endpackage

// ===== rtl/core/totient_sieve_prefix_sums.sv =====
`timescale 1ns / 1ps
// totient_sieve_prefix_sums: linear sieve of euler totient with modular prefix sums
// depends on tsps_pkg, tsps_ram, tsps_modred
//
//  channel  signals                               direction
//  in       in_valid, in_stall, restart           word in, stall out
//  out      out_valid, out_stall, number .. last  word out, stall in
//  cfg      cfg_wr_en, cfg_wr_data (limit)        write only
//
// an in-range word goes from accept to next accept through these steps, k the
// primes walked (up to the smallest prime factor of n, while p*n <= MAX_N):
// start, phi lookup, k passes of read on the prime ram, multiply, write on the
// store, sum, two reductions, output, idle; a word past the limit skips to output
// after reset a clearing pass writes all MAX_N+1 store words; the same pass
// runs on every 15th restart, when the epoch tag wraps
// in_stall is high whenever not idle; a result waits in the output register

module totient_sieve_prefix_sums
    import tsps_pkg::*;
#(
    parameter int MAX_N      = 65536,
    parameter int MAX_PRIMES = 8192
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [LIMIT_W-1:0]   cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 restart,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [NUM_W-1:0]     number,
    output logic [TOT_W-1:0]     totient,
    output logic [SUM_W-1:0]     sum_phi,
    output logic [SUM_W-1:0]     sum_phi_n,
    output logic [SUM_W-1:0]     sum_phi_n2,
    output logic                 valid_res,
    output logic                 last
);

    localparam int NW  = $clog2(MAX_N + 1);
    localparam int PAW = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
    localparam int CW  = $clog2(MAX_PRIMES + 1);
    localparam int EW  = TAG_W + 2 * NW;
    localparam int RW  = SUM_W + NW;
    localparam int LW  = (NW > LIMIT_W) ? NW : LIMIT_W;
    localparam logic [NW-1:0]    MAX_N_V   = NW'(MAX_N);
    localparam logic [CW-1:0]    MAX_P_V   = CW'(MAX_PRIMES);
    localparam logic [TAG_W-1:0] TAG_LAST  = '1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_START, S_PHI, S_RD, S_MUL, S_WR,
        S_SUM1, S_W1, S_W2, S_OUT
    } state_t;

    state_t             state_reg;
    logic               pend_reg;
    logic [TAG_W-1:0]   epoch_reg;
    logic [NW-1:0]      clr_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [NW-1:0]      cur_reg;
    logic [NW-1:0]      n_reg;
    logic [NW-1:0]      lim_reg;
    logic [NW-1:0]      ph_reg;
    logic [NW-1:0]      lpf_reg;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      j_reg;
    logic [NW-1:0]      p_reg;
    logic [2*NW-1:0]    m_reg;
    logic [NW-1:0]      php_reg;
    logic [NW-1:0]      phq_reg;
    logic               inval_reg;
    logic [SUM_W-1:0]   s0_reg, s1_reg, s2_reg;
    logic               out_valid_reg;
    logic [NUM_W-1:0]   number_reg;
    logic [TOT_W-1:0]   totient_reg;
    logic [SUM_W-1:0]   sum0_reg, sum1_reg, sum2_reg;
    logic               valid_res_reg, last_reg;

    // memory ports
    logic            st_we;
    logic [NW-1:0]   st_waddr, st_raddr;
    logic [EW-1:0]   st_wdata, st_rdata;
    logic            pl_we;
    logic [PAW-1:0]  pl_waddr, pl_raddr;
    logic [NW-1:0]   pl_rdata;

    // reducer
    logic             red_start, red_done;
    logic [RW-1:0]    red_in;
    logic [SUM_W-1:0] red_res;

    // decode of the store word for n
    logic [NW-1:0]   lim;
    logic            comp, is_one, is_prime, add_prime;
    logic [NW-1:0]   ph_new, lpf_new;
    logic [CW-1:0]   cnt_new;
    logic            hit;

    always_comb
    begin
        if (LW'(limit_reg) > LW'(MAX_N))
            lim = MAX_N_V;
        else
            lim = NW'(LW'(limit_reg));
        is_one    = (n_reg == NW'(1));
        comp      = (st_rdata[EW-1 -: TAG_W] == epoch_reg) && !is_one;
        is_prime  = !comp && !is_one;
        add_prime = is_prime && (cnt_reg < MAX_P_V);
        ph_new    = is_one ? NW'(1) : (comp ? st_rdata[2*NW-1:NW] : n_reg - 1'b1);
        lpf_new   = comp ? st_rdata[NW-1:0] : n_reg;
        cnt_new   = add_prime ? cnt_reg + 1'b1 : cnt_reg;
        hit       = (p_reg == lpf_reg);
    end

    // memory and reducer control
    always_comb
    begin
        st_we     = 1'b0;
        st_waddr  = m_reg[NW-1:0];
        st_wdata  = {epoch_reg, (hit ? php_reg : phq_reg), p_reg};
        st_raddr  = cur_reg + 1'b1;
        pl_we     = (state_reg == S_PHI) && add_prime;
        pl_waddr  = cnt_reg[PAW-1:0];
        pl_raddr  = j_reg[PAW-1:0];
        red_start = 1'b0;
        red_in    = RW'(ph_reg) * RW'(n_reg);
        case (state_reg)
            S_CLEAR:
            begin
                st_we    = 1'b1;
                st_waddr = clr_reg;
                st_wdata = '0;
            end
            S_WR:
                st_we = (m_reg <= (2*NW)'(MAX_N));
            S_SUM1:
                red_start = 1'b1;
            S_W1:
            begin
                red_start = red_done;
                red_in    = RW'(red_res) * RW'(n_reg);
            end
            default:
                ;
        endcase
    end

    // state machine, sieve state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            pend_reg      <= 1'b0;
            epoch_reg     <= '0;
            clr_reg       <= '0;
            limit_reg     <= LIMIT_W'(65536);
            cur_reg       <= '0;
            cnt_reg       <= '0;
            j_reg         <= '0;
            inval_reg     <= 1'b0;
            s0_reg        <= '0;
            s1_reg        <= '0;
            s2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                limit_reg <= cfg_wr_data;
            // output word loads in S_OUT, drops when taken
            if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    if (clr_reg == MAX_N_V)
                    begin
                        clr_reg   <= '0;
                        epoch_reg <= TAG_W'(1);
                        state_reg <= pend_reg ? S_START : S_IDLE;
                        pend_reg  <= 1'b0;
                    end
                    else
                        clr_reg <= clr_reg + 1'b1;
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (restart)
                        begin
                            cur_reg <= '0;
                            cnt_reg <= '0;
                            s0_reg  <= '0;
                            s1_reg  <= '0;
                            s2_reg  <= '0;
                            if (epoch_reg == TAG_LAST)
                            begin
                                pend_reg  <= 1'b1;
                                state_reg <= S_CLEAR;
                            end
                            else
                            begin
                                epoch_reg <= epoch_reg + 1'b1;
                                state_reg <= S_START;
                            end
                        end
                        else
                            state_reg <= S_START;
                    end
                end
                S_START:
                begin
                    n_reg   <= cur_reg + 1'b1;
                    lim_reg <= lim;
                    if (cur_reg >= lim)
                    begin
                        inval_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        inval_reg <= 1'b0;
                        state_reg <= S_PHI;
                    end
                end
                S_PHI:
                begin
                    ph_reg  <= ph_new;
                    lpf_reg <= lpf_new;
                    cnt_reg <= cnt_new;
                    cur_reg <= n_reg;
                    j_reg   <= '0;
                    state_reg <= (cnt_new == '0) ? S_SUM1 : S_RD;
                end
                S_RD:
                    state_reg <= S_MUL;
                S_MUL:
                begin
                    p_reg     <= pl_rdata;
                    m_reg     <= n_reg * pl_rdata;
                    php_reg   <= NW'(ph_reg * pl_rdata);
                    phq_reg   <= NW'(ph_reg * (pl_rdata - 1'b1));
                    state_reg <= S_WR;
                end
                S_WR:
                begin
                    if (m_reg > (2*NW)'(MAX_N) || hit || (j_reg + 1'b1) == cnt_reg)
                        state_reg <= S_SUM1;
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_SUM1:
                begin
                    s0_reg    <= add_mod(s0_reg, SUM_W'(ph_reg));
                    state_reg <= S_W1;
                end
                S_W1:
                begin
                    if (red_done)
                    begin
                        s1_reg    <= add_mod(s1_reg, red_res);
                        state_reg <= S_W2;
                    end
                end
                S_W2:
                begin
                    if (red_done)
                    begin
                        s2_reg    <= add_mod(s2_reg, red_res);
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        number_reg    <= inval_reg ? '0 : NUM_W'(n_reg);
                        totient_reg   <= inval_reg ? '0 : TOT_W'(ph_reg);
                        sum0_reg      <= inval_reg ? '0 : s0_reg;
                        sum1_reg      <= inval_reg ? '0 : s1_reg;
                        sum2_reg      <= inval_reg ? '0 : s2_reg;
                        valid_res_reg <= !inval_reg;
                        last_reg      <= !inval_reg && (n_reg == lim_reg);
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // totient store: epoch tag, phi, smallest prime factor
    tsps_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_N + 1)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // prime list
    tsps_ram #(
        .WIDTH (NW),
        .DEPTH (MAX_PRIMES)
    ) u_primes (
        .clk   (clk),
        .we    (pl_we),
        .waddr (pl_waddr),
        .wdata (n_reg),
        .raddr (pl_raddr),
        .rdata (pl_rdata)
    );

    // shared modular reducer for phi*n and (phi*n mod m)*n
    tsps_modred #(
        .WI (RW)
    ) u_red (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (red_start),
        .value  (red_in),
        .done   (red_done),
        .result (red_res)
    );

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign number     = number_reg;
    assign totient    = totient_reg;
    assign sum_phi    = sum0_reg;
    assign sum_phi_n  = sum1_reg;
    assign sum_phi_n2 = sum2_reg;
    assign valid_res  = valid_res_reg;
    assign last       = last_reg;

endmodule

// ===== rtl/core/tsps_ram.sv =====
`timescale 1ns / 1ps
// tsps_ram: generic single write, single read ram with registered read
// no dependencies

module tsps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/tsps_modred.sv =====
`timescale 1ns / 1ps
// tsps_modred: reduces a wide product modulo 998244353 by a reciprocal estimate
// depends on tsps_pkg

module tsps_modred
    import tsps_pkg::*;
#(
    parameter int WI = 47
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WI-1:0]    value,
    output logic             done,
    output logic [SUM_W-1:0] result
);

    // quotient estimate from bit 29 upward, at most two below the true one
    localparam int K  = WI - 29;
    localparam int QW = K + SUM_W;
    localparam longint unsigned RECIP = (64'd1 << WI) / 64'(MODULUS);
    localparam logic [K-1:0] RECIP_V  = K'(RECIP);
    localparam logic [31:0]  MOD1     = 32'(MODULUS);
    localparam logic [31:0]  MOD2     = MOD1 << 1;

    logic            st1_reg;
    logic            st2_reg;
    logic            done_reg;
    logic [WI-1:0]   x_reg;
    logic [K-1:0]    q_reg;
    logic [31:0]     r_reg;
    logic [2*K-1:0]  qe;
    logic [QW-1:0]   qm;
    logic [31:0]     r_fin;

    // estimate, product of quotient and modulus, final correction
    always_comb
    begin
        qe = (2*K)'(x_reg[WI-1:29]) * (2*K)'(RECIP_V);
        qm = QW'(q_reg) * QW'(MODULUS);
        if (r_reg >= MOD2)
            r_fin = r_reg - MOD2;
        else if (r_reg >= MOD1)
            r_fin = r_reg - MOD1;
        else
            r_fin = r_reg;
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_reg  <= 1'b0;
            st2_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            st1_reg  <= start;
            st2_reg  <= st1_reg;
            done_reg <= st2_reg;
        end
    end

    // operand, quotient and remainder below 3*modulus
    always_ff @(posedge clk)
    begin
        if (start)
            x_reg <= value;
        if (st1_reg)
            q_reg <= qe[2*K-1:K];
        if (st2_reg)
            r_reg <= x_reg[31:0] - qm[31:0];
    end

    assign done   = done_reg;
    assign result = r_fin[SUM_W-1:0];

endmodule
